// ----- rtl/counter_multiplex_scaler_assert.svh -----
// Assertion macros used by the checker file.
`ifndef COUNTER_MULTIPLEX_SCALER_ASSERT_SVH
`define COUNTER_MULTIPLEX_SCALER_ASSERT_SVH

// a in this cycle implies b in this cycle
`define CMS_ASSERT_NOW(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
    else $error("%m: check failed");

// a in this cycle implies b in the next cycle
`define CMS_ASSERT_NEXT(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
    else $error("%m: check failed");

`endif

// ----- rtl/cms_pkg.sv -----
// ----------------------------------------------------------------------------
// cms_pkg
// Types, constants and the divide step of the counter scaler.
// ----------------------------------------------------------------------------
package cms_pkg;

  localparam int COUNT_WIDTH = 64;
  localparam logic [63:0] CNT_MASK = 64'((65'd1 << COUNT_WIDTH) - 65'd1);

  // quotient bits retired per divider stage, and the number of stages
  localparam int BITS_PER_STAGE = 2;
  localparam int DIV_STAGES = 64 / BITS_PER_STAGE;

  typedef struct packed {
    logic [63:0] rem;
    logic [63:0] lo;
    logic [63:0] q;
    logic [63:0] run;
    logic        scale;
    logic        ovf;
  } div_t;

  // one restoring step: shift a numerator bit into the remainder
  function automatic div_t div_step(input div_t s);
    div_t        r;
    logic [64:0] t;
    r = s;
    t = {s.rem, s.lo[63]};
    if (s.scale && !s.ovf) begin
      r.lo = {s.lo[62:0], 1'b0};
      if (t >= {1'b0, s.run}) begin
        r.rem = 64'(t - {1'b0, s.run});
        r.q   = {s.q[62:0], 1'b1};
      end else begin
        r.rem = t[63:0];
        r.q   = {s.q[62:0], 1'b0};
      end
    end
    return r;
  endfunction

endpackage

// ----- rtl/counter_multiplex_scaler.sv -----
// ----------------------------------------------------------------------------
// counter_multiplex_scaler
// Scales a multiplexed event count by enabled over running time.
// ----------------------------------------------------------------------------
// Accepts one item per cycle unless the output stalls, and returns
// scaled_count = raw_count * ena_time / run_time (truncated), with
// pass-through when the counter ran the whole time and zero when it never
// ran. One stage forms 32x32 partial products, one sums the 128-bit product,
// one sets up, then 32 divider stages retire two quotient bits each. The
// pipeline moves as a whole, so a stall on the output holds every stage.
module counter_multiplex_scaler (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [63:0] raw_count,
  input  logic [63:0] ena_time,
  input  logic [63:0] run_time,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [63:0] scaled_count,
  output logic        was_scaled,
  output logic        overflowed
);

  localparam int NST = cms_pkg::DIV_STAGES + 1;

  logic advance;

  // product stage
  logic        v1;
  logic [63:0] p00, p01, p10, p11, raw1, run1;
  logic        zero1, pass1;
  // sum stage
  logic        v2;
  logic [127:0] prod2;
  logic [63:0] raw2, run2;
  logic        zero2, pass2;
  // setup and divider stages
  logic          v [NST];
  cms_pkg::div_t st [NST];

  logic [63:0] raw_m;
  assign raw_m = raw_count & cms_pkg::CNT_MASK;

  assign advance  = !v[NST-1] || out_ready;
  assign in_ready = advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else if (advance) begin
      v1 <= in_valid;
      v2 <= v1;
    end
    if (advance) begin
      p00   <= 64'(raw_m[31:0])  * 64'(ena_time[31:0]);
      p01   <= 64'(raw_m[31:0])  * 64'(ena_time[63:32]);
      p10   <= 64'(raw_m[63:32]) * 64'(ena_time[31:0]);
      p11   <= 64'(raw_m[63:32]) * 64'(ena_time[63:32]);
      raw1  <= raw_m;
      run1  <= run_time;
      zero1 <= (run_time == 64'd0);
      pass1 <= (run_time >= ena_time);
      prod2 <= {64'd0, p00} + {32'd0, p01, 32'd0} + {32'd0, p10, 32'd0}
               + {p11, 64'd0};
      raw2  <= raw1;
      run2  <= run1;
      zero2 <= zero1;
      pass2 <= pass1;
    end
  end

  // setup: pick the mode and flag a quotient that cannot fit in 64 bits
  always_ff @(posedge clk) begin
    if (rst) begin
      v[0] <= 1'b0;
    end else if (advance) begin
      v[0] <= v2;
    end
    if (advance) begin
      st[0].run <= run2;
      st[0].rem <= prod2[127:64];
      st[0].lo  <= prod2[63:0];
      if (zero2) begin
        st[0].q     <= 64'd0;
        st[0].scale <= 1'b0;
        st[0].ovf   <= 1'b0;
      end else if (pass2) begin
        st[0].q     <= raw2;
        st[0].scale <= 1'b0;
        st[0].ovf   <= 1'b0;
      end else begin
        st[0].q     <= 64'd0;
        st[0].scale <= 1'b1;
        st[0].ovf   <= (prod2[127:64] >= run2);
      end
    end
  end

  for (genvar i = 1; i < NST; i++) begin : g_div
    cms_pkg::div_t s [cms_pkg::BITS_PER_STAGE+1];
    always_comb begin
      s[0] = st[i-1];
      for (int k = 0; k < cms_pkg::BITS_PER_STAGE; k++) begin
        s[k+1] = cms_pkg::div_step(s[k]);
      end
    end
    always_ff @(posedge clk) begin
      if (rst) begin
        v[i] <= 1'b0;
      end else if (advance) begin
        v[i] <= v[i-1];
      end
      if (advance) begin
        st[i] <= s[cms_pkg::BITS_PER_STAGE];
      end
    end
  end

  logic sat;
  assign sat = st[NST-1].scale && (st[NST-1].ovf || st[NST-1].q > cms_pkg::CNT_MASK);

  assign out_valid    = v[NST-1];
  assign was_scaled   = st[NST-1].scale;
  assign overflowed   = sat;
  assign scaled_count = sat ? cms_pkg::CNT_MASK : (st[NST-1].q & cms_pkg::CNT_MASK);

endmodule

// ----- rtl/cms_checker.sv -----
// ----------------------------------------------------------------------------
// cms_checker
// Port-level checks of the counter scaler, bound to the top level.
// ----------------------------------------------------------------------------
`include "counter_multiplex_scaler_assert.svh"

module cms_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [63:0] scaled_count,
  input logic        was_scaled,
  input logic        overflowed
);

  `CMS_ASSERT_NEXT(a_hold, clk, rst, out_valid && !out_ready, out_valid && $stable(scaled_count))
  `CMS_ASSERT_NOW(a_stall, clk, rst, out_valid && !out_ready, !in_ready)
  `CMS_ASSERT_NOW(a_ovf_scaled, clk, rst, out_valid && overflowed, was_scaled)
  `CMS_ASSERT_NOW(a_ovf_sat, clk, rst, out_valid && overflowed, scaled_count == cms_pkg::CNT_MASK)

endmodule

bind counter_multiplex_scaler cms_checker u_cms_checker (
  .clk(clk),
  .rst(rst),
  .in_ready(in_ready),
  .out_valid(out_valid),
  .out_ready(out_ready),
  .scaled_count(scaled_count),
  .was_scaled(was_scaled),
  .overflowed(overflowed)
);
